// ----- src/scaled_grid_thumbnail_rasterizer_unit_macros.svh -----
// assertion macros used by the thumbnail rasterizer sequencer
`ifndef SCALED_GRID_THUMBNAIL_RASTERIZER_UNIT_MACROS_SVH
`define SCALED_GRID_THUMBNAIL_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SGTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sgtr_pkg.sv -----
// shared types, codes and constants of the thumbnail rasterizer
package sgtr_pkg;

    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;

    localparam logic [3:0] MAX_CELL_SIZE = 4'd8;
    localparam logic [3:0] MIN_ANT_SIZE  = 4'd3;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_CELL  = 2'd1;
    localparam logic [1:0] ACT_ANT   = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [2:0] CFG_GRID_W  = 3'd0;
    localparam logic [2:0] CFG_GRID_H  = 3'd1;
    localparam logic [2:0] CFG_MAX_W   = 3'd2;
    localparam logic [2:0] CFG_MAX_H   = 3'd3;
    localparam logic [2:0] CFG_DEAD    = 3'd4;
    localparam logic [2:0] CFG_ALIVE   = 3'd5;
    localparam logic [2:0] CFG_ANT     = 3'd6;

    localparam logic [15:0] RST_GRID_W = 16'd64;
    localparam logic [15:0] RST_GRID_H = 16'd64;
    localparam logic [8:0]  RST_MAX_W  = 9'd256;
    localparam logic [8:0]  RST_MAX_H  = 9'd256;
    localparam logic [23:0] RST_DEAD   = 24'h000000;
    localparam logic [23:0] RST_ALIVE  = 24'hFFFFFF;
    localparam logic [23:0] RST_ANT    = 24'hFF0000;

    localparam int DIV_STEPS = 25;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [15:0] grid_width;
        logic [15:0] grid_height;
        logic [8:0]  max_image_width;
        logic [8:0]  max_image_height;
        logic [23:0] dead_color;
        logic [23:0] alive_color;
        logic [23:0] ant_color;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [24:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [24:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic        we;
        logic        re;
        logic [8:0]  x;
        logic [8:0]  y;
        logic [23:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [23:0] pixel_color;
        logic [8:0]  image_width;
        logic [8:0]  image_height;
        logic        in_range;
    } t_result;

endpackage

// ----- src/sgtr_div.sv -----
// shared iterative restoring divider, one quotient bit per cycle
module sgtr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgtr_pkg::t_div_req i_req,
    output sgtr_pkg::t_div_rsp o_rsp
);
    import sgtr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_rem;
    logic [24:0]          r_quo;
    logic [15:0]          r_den;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    assign shifted = {r_rem, r_quo[24]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= ge ? diff[15:0] : shifted[15:0];
            r_quo <= {r_quo[23:0], ge};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quotient: r_quo};

endmodule

// ----- src/sgtr_fstore.sv -----
// single-port frame store, registered read
module sgtr_fstore #(
    parameter int FRAME_WIDTH  = sgtr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgtr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  sgtr_pkg::t_mem_req i_req,
    output logic [23:0]       o_rdata
);
    import sgtr_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [23:0]   r_mem [DEPTH];
    logic [23:0]   r_rdata;
    logic [AW-1:0] addr;

    assign addr = AW'(i_req.y) * AW'(FRAME_WIDTH) + AW'(i_req.x);

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sgtr_seq.sv -----
// command sequencer: sizing, origins, clipping, pixel sweep and pixel read
`include "scaled_grid_thumbnail_rasterizer_unit_macros.svh"

module sgtr_seq #(
    parameter int FRAME_WIDTH  = sgtr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgtr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_col,
    input  logic [15:0]        i_row,
    input  sgtr_pkg::t_cfg     i_cfg,
    input  logic               i_out_free,
    output logic               o_res_valid,
    output sgtr_pkg::t_result  o_res,
    output sgtr_pkg::t_div_req o_div_req,
    input  sgtr_pkg::t_div_rsp i_div_rsp,
    output sgtr_pkg::t_mem_req o_mem_req,
    input  logic [23:0]        i_mem_rdata
);
    import sgtr_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_CLR_CMP  = 4'd2;
    localparam logic [3:0] S_SHR_WAIT = 4'd3;
    localparam logic [3:0] S_FIT_D1   = 4'd4;
    localparam logic [3:0] S_FIT_D2   = 4'd5;
    localparam logic [3:0] S_FIT_MUL  = 4'd6;
    localparam logic [3:0] S_DRAW     = 4'd7;
    localparam logic [3:0] S_OX_WAIT  = 4'd8;
    localparam logic [3:0] S_OY_WAIT  = 4'd9;
    localparam logic [3:0] S_RECT     = 4'd10;
    localparam logic [3:0] S_SWEEP    = 4'd11;
    localparam logic [3:0] S_RD       = 4'd12;
    localparam logic [3:0] S_RD_DATA  = 4'd13;
    localparam logic [3:0] S_FIN      = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_act, n_act;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [23:0] r_pix, n_pix;
    logic        r_inr, n_inr;
    logic [8:0]  r_cur_w, n_cur_w;
    logic [8:0]  r_cur_h, n_cur_h;
    logic [3:0]  r_scale, n_scale;
    logic        r_mode, n_mode;
    logic [24:0] r_pa, n_pa;
    logic [24:0] r_pb, n_pb;
    logic        r_wdec, n_wdec;
    logic [3:0]  r_s1, n_s1;
    logic [19:0] r_ox, n_ox;
    logic [19:0] r_oy, n_oy;
    logic [8:0]  r_x, n_x;
    logic [8:0]  r_y, n_y;
    logic [8:0]  r_l, n_l;
    logic [8:0]  r_r, n_r;
    logic [8:0]  r_b, n_b;
    logic [23:0] r_color, n_color;

    logic [8:0]         mw;
    logic [8:0]         mh;
    logic [3:0]         q_cap;
    logic [8:0]         q_min1;
    logic [3:0]         sq;
    logic signed [21:0] off;
    logic signed [21:0] x0, x1, y0, y1;
    logic signed [21:0] lx, rx, ty, by;
    logic signed [21:0] cur_x, cur_y;
    logic [8:0]         fill_w, fill_h;

    assign mw = ({4'd0, i_cfg.max_image_width} > 13'(FRAME_WIDTH)) ?
                9'(FRAME_WIDTH) : i_cfg.max_image_width;
    assign mh = ({4'd0, i_cfg.max_image_height} > 13'(FRAME_HEIGHT)) ?
                9'(FRAME_HEIGHT) : i_cfg.max_image_height;

    assign q_cap  = (i_div_rsp.quotient > 25'(MAX_CELL_SIZE)) ?
                    MAX_CELL_SIZE : i_div_rsp.quotient[3:0];
    assign q_min1 = (i_div_rsp.quotient == '0) ? 9'd1 : i_div_rsp.quotient[8:0];

    // square geometry, clipped to the image
    assign sq    = (r_act == ACT_CELL || r_scale > MIN_ANT_SIZE) ? r_scale : MIN_ANT_SIZE;
    assign off   = $signed(22'(r_scale >> 1)) - $signed(22'(sq >> 1));
    assign x0    = $signed({2'b00, r_ox}) + off;
    assign y0    = $signed({2'b00, r_oy}) + off;
    assign x1    = x0 + $signed(22'(sq));
    assign y1    = y0 + $signed(22'(sq));
    assign cur_x = $signed(22'(r_cur_w));
    assign cur_y = $signed(22'(r_cur_h));
    assign lx    = (x0 < 0) ? '0 : x0;
    assign ty    = (y0 < 0) ? '0 : y0;
    assign rx    = (x1 > cur_x) ? cur_x : x1;
    assign by    = (y1 > cur_y) ? cur_y : y1;

    assign fill_w = 9'(i_cfg.grid_width * 16'(r_scale));
    assign fill_h = 9'(i_cfg.grid_height * 16'(r_scale));

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_col   = r_col;
        n_row   = r_row;
        n_pix   = r_pix;
        n_inr   = r_inr;
        n_cur_w = r_cur_w;
        n_cur_h = r_cur_h;
        n_scale = r_scale;
        n_mode  = r_mode;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_wdec  = r_wdec;
        n_s1    = r_s1;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_x     = r_x;
        n_y     = r_y;
        n_l     = r_l;
        n_r     = r_r;
        n_b     = r_b;
        n_color = r_color;

        o_div_req   = '{start: 1'b0, dividend: '0, divisor: '0};
        o_mem_req   = '{we: 1'b0, re: 1'b0, x: r_x, y: r_y, wdata: r_color};
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act = i_action;
                    n_col = i_col;
                    n_row = i_row;
                    n_pix = '0;
                    n_inr = 1'b0;
                    unique case (i_action) inside
                        ACT_CLEAR:         n_state = S_CLR;
                        ACT_CELL, ACT_ANT: n_state = S_DRAW;
                        ACT_READ:          n_state = S_RD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                n_scale = 4'd1;
                n_mode  = 1'b0;
                if (i_cfg.grid_width == '0 || i_cfg.grid_height == '0 ||
                    mw == '0 || mh == '0) begin
                    n_cur_w = '0;
                    n_cur_h = '0;
                    n_state = S_FIN;
                end else if (i_cfg.grid_width > 16'(mw) ||
                             i_cfg.grid_height > 16'(mh)) begin
                    n_mode  = 1'b1;
                    n_pa    = 25'(mw) * 25'(i_cfg.grid_height);
                    n_pb    = 25'(mh) * 25'(i_cfg.grid_width);
                    n_state = S_CLR_CMP;
                end else begin
                    o_div_req = '{start: 1'b1, dividend: 25'(mw),
                                  divisor: i_cfg.grid_width};
                    n_state   = S_FIT_D1;
                end
            end
            S_CLR_CMP: begin
                n_wdec = (r_pa <= r_pb);
                if (r_pa <= r_pb) begin
                    o_div_req = '{start: 1'b1, dividend: r_pa,
                                  divisor: i_cfg.grid_width};
                end else begin
                    o_div_req = '{start: 1'b1, dividend: r_pb,
                                  divisor: i_cfg.grid_height};
                end
                n_state = S_SHR_WAIT;
            end
            S_SHR_WAIT: begin
                if (i_div_rsp.done) begin
                    n_cur_w = r_wdec ? mw : q_min1;
                    n_cur_h = r_wdec ? q_min1 : mh;
                    n_x     = '0;
                    n_y     = '0;
                    n_l     = '0;
                    n_r     = r_wdec ? mw : q_min1;
                    n_b     = r_wdec ? q_min1 : mh;
                    n_color = i_cfg.dead_color;
                    n_state = S_SWEEP;
                end
            end
            S_FIT_D1: begin
                if (i_div_rsp.done) begin
                    n_s1      = q_cap;
                    o_div_req = '{start: 1'b1, dividend: 25'(mh),
                                  divisor: i_cfg.grid_height};
                    n_state   = S_FIT_D2;
                end
            end
            S_FIT_D2: begin
                if (i_div_rsp.done) begin
                    n_scale = (q_cap < r_s1) ? q_cap : r_s1;
                    n_state = S_FIT_MUL;
                end
            end
            S_FIT_MUL: begin
                n_cur_w = fill_w;
                n_cur_h = fill_h;
                n_x     = '0;
                n_y     = '0;
                n_l     = '0;
                n_r     = fill_w;
                n_b     = fill_h;
                n_color = i_cfg.dead_color;
                n_state = S_SWEEP;
            end
            S_DRAW: begin
                if (r_col < i_cfg.grid_width && r_row < i_cfg.grid_height) begin
                    n_inr = 1'b1;
                    if (r_mode) begin
                        o_div_req = '{start: 1'b1,
                                      dividend: 25'(r_col) * 25'(r_cur_w),
                                      divisor: i_cfg.grid_width};
                        n_state   = S_OX_WAIT;
                    end else begin
                        n_ox    = 20'(r_col) * 20'(r_scale);
                        n_oy    = 20'(r_row) * 20'(r_scale);
                        n_state = S_RECT;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_OX_WAIT: begin
                if (i_div_rsp.done) begin
                    n_ox      = 20'(i_div_rsp.quotient);
                    o_div_req = '{start: 1'b1,
                                  dividend: 25'(r_row) * 25'(r_cur_h),
                                  divisor: i_cfg.grid_height};
                    n_state   = S_OY_WAIT;
                end
            end
            S_OY_WAIT: begin
                if (i_div_rsp.done) begin
                    n_oy    = 20'(i_div_rsp.quotient);
                    n_state = S_RECT;
                end
            end
            S_RECT: begin
                if (lx >= rx || ty >= by) begin
                    n_state = S_FIN;
                end else begin
                    n_x     = lx[8:0];
                    n_l     = lx[8:0];
                    n_r     = rx[8:0];
                    n_y     = ty[8:0];
                    n_b     = by[8:0];
                    n_color = (r_act == ACT_CELL) ? i_cfg.alive_color : i_cfg.ant_color;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_mem_req.we = 1'b1;
                if (r_x + 9'd1 == r_r) begin
                    n_x = r_l;
                    if (r_y + 9'd1 == r_b) begin
                        n_state = S_FIN;
                    end else begin
                        n_y = r_y + 9'd1;
                    end
                end else begin
                    n_x = r_x + 9'd1;
                end
            end
            S_RD: begin
                if (r_col < 16'(r_cur_w) && r_row < 16'(r_cur_h)) begin
                    o_mem_req.re = 1'b1;
                    o_mem_req.x  = r_col[8:0];
                    o_mem_req.y  = r_row[8:0];
                    n_inr        = 1'b1;
                    n_state      = S_RD_DATA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD_DATA: begin
                n_pix   = i_mem_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res = '{pixel_color: r_pix, image_width: r_cur_w,
                     image_height: r_cur_h, in_range: r_inr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur_w <= '0;
            r_cur_h <= '0;
            r_scale <= 4'd1;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur_w <= n_cur_w;
            r_cur_h <= n_cur_h;
            r_scale <= n_scale;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_col   <= n_col;
        r_row   <= n_row;
        r_pix   <= n_pix;
        r_inr   <= n_inr;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_wdec  <= n_wdec;
        r_s1    <= n_s1;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_x     <= n_x;
        r_y     <= n_y;
        r_l     <= n_l;
        r_r     <= n_r;
        r_b     <= n_b;
        r_color <= n_color;
    end

    `SGTR_ASSERT_NOW(a_div_start_idle, i_clk, i_rst_n, o_div_req.start, !i_div_rsp.busy, "divider started while busy")
    `SGTR_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, o_div_req.start, i_div_rsp.busy, "divider did not take start")
    `SGTR_ASSERT_NOW(a_write_in_image, i_clk, i_rst_n, o_mem_req.we, (o_mem_req.x < r_cur_w) && (o_mem_req.y < r_cur_h), "pixel write outside image")
    `SGTR_ASSERT_NOW(a_sweep_bounds, i_clk, i_rst_n, r_state == S_SWEEP, (r_x >= r_l) && (r_x < r_r) && (r_y < r_b), "sweep left its rectangle")

endmodule

// ----- src/scaled_grid_thumbnail_rasterizer_unit.sv -----
// Thumbnail rasterizer top level: a command stream (clear and size, draw cell, draw ant,
// read pixel) drives a sequencer around one shared divider and a single-port frame
// store. One command is in flight at a time and each returns one result. A clear makes
// one divider pass when the grid is shrunk or two passes when it fits, then fills every
// image pixel with the dead colour; an empty image gets no divider pass and no fill. A
// draw outside the grid writes nothing; otherwise it makes two origin divisions in
// shrink mode and writes each clipped pixel of the square (at most 64). A finished
// command holds in the sequencer while the output register is full and not drained.
// The one write port of the frame store takes every fill and draw write; a result waits
// in the output register while the next command is taken.
module scaled_grid_thumbnail_rasterizer_unit #(
    parameter int FRAME_WIDTH  = sgtr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgtr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // col[15:0], row[31:16]
    input  logic [1:0]  i_s_axis_tuser,  // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // pixel_color[23:0], image_width[32:24],
                                         // image_height[41:33], zero[47:42]
    output logic        o_m_axis_tuser,  // in_range
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import sgtr_pkg::*;

    t_cfg     r_cfg;
    t_result  r_out;
    logic     r_out_valid;
    t_result  res;
    logic     res_valid;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mem_req mem_req;
    logic [23:0] mem_rdata;
    logic     out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{grid_width: RST_GRID_W, grid_height: RST_GRID_H,
                       max_image_width: RST_MAX_W, max_image_height: RST_MAX_H,
                       dead_color: RST_DEAD, alive_color: RST_ALIVE,
                       ant_color: RST_ANT};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_W: r_cfg.grid_width       <= i_cfg_data[15:0];
                CFG_GRID_H: r_cfg.grid_height      <= i_cfg_data[15:0];
                CFG_MAX_W:  r_cfg.max_image_width  <= i_cfg_data[8:0];
                CFG_MAX_H:  r_cfg.max_image_height <= i_cfg_data[8:0];
                CFG_DEAD:   r_cfg.dead_color       <= i_cfg_data;
                CFG_ALIVE:  r_cfg.alive_color      <= i_cfg_data;
                CFG_ANT:    r_cfg.ant_color        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.image_height, r_out.image_width, r_out.pixel_color};
    assign o_m_axis_tuser  = r_out.in_range;

    sgtr_seq #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_col       (i_s_axis_tdata[15:0]),
        .i_row       (i_s_axis_tdata[31:16]),
        .i_cfg       (r_cfg),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    sgtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sgtr_fstore #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_fstore (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
